// ===== hdl/rafb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rafb_pkg;

	// default size of the memory window in bytes
	localparam int MEM_BYTES_DEF = 256;

	// command and reply codes
	localparam logic [7:0] CMD_READ     = 8'h0a;
	localparam logic [7:0] CMD_REPLY    = 8'h0b;
	localparam logic [7:0] REPLY_STATUS = 8'h00;

	// window base after reset
	localparam logic [15:0] BASE_RESET = 16'h4000;

	// header layout
	localparam int          HDR_BYTES = 8;
	localparam logic [2:0]  HDR_CMD   = 3'd0;
	localparam logic [2:0]  HDR_LENH  = 3'd4;
	localparam logic [2:0]  HDR_LENL  = 3'd5;
	localparam logic [2:0]  HDR_ADDRH = 3'd6;
	localparam logic [2:0]  HDR_LAST  = 3'(HDR_BYTES - 1);

	// reply frame prefix length (reply code, length pair, status)
	localparam int REPLY_PREFIX = 4;

	// one result word as it leaves the back end
	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  count;
		logic        last;
		logic        clamped;
	} resp_t;

endpackage

`default_nettype wire

// ===== hdl/rafb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rafb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rafb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rafb_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] head_data,
	output logic                  empty
);

	logic [WIDTH-1:0] data_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign empty     = (cnt_q == 2'd0);
	assign head_data = data_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			data_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rafb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rafb_front #(
	parameter int MEM_BYTES = rafb_pkg::MEM_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    stream_byte,
	input  wire logic                          new_session,
	input  wire logic [15:0]                   window_base,
	input  wire logic                          busy,
	input  wire logic                          q_full,
	output logic                               q_push,
	output logic [2*$clog2(MEM_BYTES)+2:0]     q_data,
	output logic                               ram_we,
	output logic [$clog2(MEM_BYTES)-1:0]       ram_waddr,
	output logic [7:0]                         ram_wdata
);

	import rafb_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int LW = AW + 1;

	logic           clearing_q;
	logic [AW-1:0]  clr_q;
	logic [2:0]     hidx_q;
	logic           in_pay_q;
	logic [15:0]    left_q;
	logic [AW-1:0]  wp_q;
	logic           allow_q;
	logic [7:0]     cmd_q;
	logic [7:0]     lenh_q;
	logic [7:0]     lenl_q;
	logic [7:0]     addrh_q;

	logic           eff_pay;
	logic [2:0]     eff_idx;
	logic [15:0]    len16;
	logic [15:0]    addr16;
	logic           is_read;
	logic           final_hdr;
	logic           clamped;
	logic [LW-1:0]  rd_len;
	logic [16:0]    span_len;
	logic [16:0]    diff;
	logic [16:0]    reach;
	logic           in_win;
	logic [AW-1:0]  off;
	logic           acc;

	// header decode and window check on the last header byte
	always_comb begin
		eff_pay   = in_pay_q && !new_session;
		eff_idx   = new_session ? HDR_CMD : hidx_q;
		len16     = {lenh_q, lenl_q};
		addr16    = {addrh_q, stream_byte};
		is_read   = (cmd_q == CMD_READ);
		final_hdr = !eff_pay && (eff_idx == HDR_LAST);
		clamped   = (len16 > 16'(MEM_BYTES));
		rd_len    = clamped ? LW'(MEM_BYTES) : len16[LW-1:0];
		span_len  = is_read ? 17'(rd_len) : {1'b0, len16};
		diff      = {1'b0, addr16} - {1'b0, window_base};
		reach     = {1'b0, diff[15:0]} + span_len;
		in_win    = !diff[16] && (reach <= 17'(MEM_BYTES));
		off       = diff[AW-1:0];
	end

	// handshake: stall while clearing, hold memory writes while a read frame is pending and read headers on a full queue
	always_comb begin
		in_ready = !clearing_q
			&& !(eff_pay && allow_q && busy)
			&& !(final_hdr && is_read && q_full);
		acc    = in_valid && in_ready;
		q_push = acc && final_hdr && is_read;
		q_data = {off, rd_len, in_win, clamped};
	end

	// memory write port: clearing sweep first, then payload bytes
	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 8'h00;
		end else begin
			ram_we    = acc && eff_pay && allow_q;
			ram_waddr = wp_q;
			ram_wdata = stream_byte;
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(MEM_BYTES - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// stored header fields
	always_ff @(posedge clk) begin
		if (acc && !eff_pay) begin
			case (eff_idx)
				HDR_CMD:   cmd_q   <= stream_byte;
				HDR_LENH:  lenh_q  <= stream_byte;
				HDR_LENL:  lenl_q  <= stream_byte;
				HDR_ADDRH: addrh_q <= stream_byte;
				default:   ;
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidx_q   <= 3'd0;
			in_pay_q <= 1'b0;
			left_q   <= 16'd0;
			wp_q     <= '0;
			allow_q  <= 1'b0;
		end else if (acc) begin
			if (new_session) begin
				allow_q <= 1'b0;
			end
			if (eff_pay) begin
				wp_q   <= wp_q + AW'(1);
				left_q <= left_q - 16'd1;
				if (left_q == 16'd1) begin
					in_pay_q <= 1'b0;
					allow_q  <= 1'b0;
				end
			end else if (eff_idx == HDR_LAST) begin
				hidx_q   <= 3'd0;
				in_pay_q <= 1'b0;
				if (!is_read && len16 != 16'd0) begin
					in_pay_q <= 1'b1;
					left_q   <= len16;
					allow_q  <= in_win;
					wp_q     <= off;
				end
			end else begin
				hidx_q   <= eff_idx + 3'd1;
				in_pay_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rafb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rafb_back #(
	parameter int MEM_BYTES = rafb_pkg::MEM_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire logic [2*$clog2(MEM_BYTES)+2:0] q_data,
	output logic                               q_pop,
	output logic                               active,
	output logic                               ram_re,
	output logic [$clog2(MEM_BYTES)-1:0]       ram_raddr,
	input  wire logic [7:0]                    ram_rdata,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output rafb_pkg::resp_t                    resp
);

	import rafb_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int LW = AW + 1;
	localparam int PW = AW + 2;

	// command fields from the queue head
	logic [AW-1:0]  h_off;
	logic [LW-1:0]  h_len;
	logic           h_inside;
	logic           h_clamped;

	logic           active_q;
	logic [AW-1:0]  off_q;
	logic [PW-1:0]  pos_q;
	logic [PW-1:0]  lastpos_q;
	logic [15:0]    flen_q;
	logic           inside_q;
	logic           clamped_q;

	logic           v_s1;
	logic [7:0]     hb_s1;
	logic           data_s1;
	logic           last_s1;
	logic           clamped_s1;

	logic [63:0]    word_q;
	logic [2:0]     cnt_q;
	logic           out_valid_q;
	resp_t          out_q;

	logic           out_free;
	logic [7:0]     byte_s1;
	logic           finish;
	logic           take;
	logic           adv;
	logic           load;
	logic           is_last;
	logic [7:0]     hb;
	logic [2:0]     lane;
	logic [63:0]    new_word;

	assign {h_off, h_len, h_inside, h_clamped} = q_data;
	assign active    = active_q;
	assign out_valid = out_valid_q;
	assign resp      = out_q;

	// prefix bytes of the reply frame
	always_comb begin
		hb = 8'h00;
		if (pos_q < PW'(REPLY_PREFIX)) begin
			case (pos_q[1:0])
				2'd0:    hb = CMD_REPLY;
				2'd1:    hb = flen_q[15:8];
				2'd2:    hb = flen_q[7:0];
				default: hb = REPLY_STATUS;
			endcase
		end
	end

	// flow control across issue, byte and packing stages
	always_comb begin
		out_free  = !out_valid_q || out_ready;
		byte_s1   = data_s1 ? ram_rdata : hb_s1;
		finish    = last_s1 || (cnt_q == 3'd7);
		take      = v_s1 && (!finish || out_free);
		adv       = active_q && (!v_s1 || take);
		load      = !active_q && !q_empty;
		q_pop     = load;
		is_last   = (pos_q == lastpos_q);
		ram_re    = adv;
		ram_raddr = off_q + AW'(pos_q - PW'(REPLY_PREFIX));
		lane      = 3'd7 - cnt_q;
		new_word  = word_q;
		new_word[{lane, 3'b000} +: 8] = byte_s1;
	end

	// frame command registers
	always_ff @(posedge clk) begin
		if (load) begin
			off_q     <= h_off;
			lastpos_q <= PW'(h_len) + PW'(REPLY_PREFIX - 1);
			flen_q    <= 16'(h_len) + 16'(REPLY_PREFIX);
			inside_q  <= h_inside;
			clamped_q <= h_clamped;
		end
	end

	// byte position within the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			pos_q    <= '0;
		end else if (adv) begin
			pos_q <= pos_q + PW'(1);
			if (is_last) begin
				active_q <= 1'b0;
			end
		end
	end

	// byte stage, aligned with the memory read data
	always_ff @(posedge clk) begin
		if (adv) begin
			hb_s1      <= hb;
			data_s1    <= inside_q && (pos_q >= PW'(REPLY_PREFIX));
			last_s1    <= is_last;
			clamped_s1 <= clamped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= 1'b1;
		end else if (take) begin
			v_s1 <= 1'b0;
		end
	end

	// packing of bytes into words, first byte at the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			cnt_q  <= 3'd0;
		end else if (take) begin
			if (finish) begin
				word_q <= '0;
				cnt_q  <= 3'd0;
			end else begin
				word_q <= new_word;
				cnt_q  <= cnt_q + 3'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (take && finish) begin
			out_q.word    <= new_word;
			out_q.count   <= 4'(cnt_q) + 4'd1;
			out_q.last    <= last_s1;
			out_q.clamped <= clamped_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/register_access_frame_bridge.sv =====
// Register access frame bridge. Takes a command stream one byte per item and
// parses 8-byte headers (command, big-endian length at bytes 4-5, big-endian
// address at bytes 6-7). A read command (0x0a) produces a reply frame of 0x0b,
// the frame length (4 + len) and a zero status, followed by len bytes from a
// MEM_BYTES memory window starting at window_base, or zeros if the span falls
// outside it; the frame leaves packed eight bytes per word, first byte at the
// top, out_last on the final word. Read lengths above MEM_BYTES are clamped and
// flagged on len_clamped. Any other command is a write whose payload is stored
// only if the whole span lies inside the window. Header and payload bytes are
// taken one per cycle unless the sweep, a full queue or a pending read holds
// them. A read frame leaves the queue and then passes through the back end
// one byte per cycle through the single read port of the window memory, while
// the output is not stalled; two read commands can queue behind it, and
// payload bytes of an in-window write wait until all queued reads have read
// their data. After reset the window memory is swept to zero, during which
// no item is taken; window_base may be written at any time the block is idle
// and is always ready.
`timescale 1ns / 1ps
`default_nettype none

module register_access_frame_bridge #(
	parameter int MEM_BYTES = rafb_pkg::MEM_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  stream_byte,
	input  wire logic        new_session,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      out_word,
	output logic [3:0]       out_count,
	output logic             out_last,
	output logic             len_clamped
);

	import rafb_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int QW = 2 * AW + 3;

	logic [15:0]   base_q;
	logic          busy;
	logic          back_active;
	logic          q_full;
	logic          q_empty;
	logic          q_push;
	logic          q_pop;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	resp_t         resp;

	// window base register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	// a read frame still owes memory reads
	assign busy = back_active || !q_empty;

	rafb_front #(
		.MEM_BYTES(MEM_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.stream_byte(stream_byte),
		.new_session(new_session),
		.window_base(base_q),
		.busy       (busy),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	rafb_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.head_data(q_rdata),
		.empty    (q_empty)
	);

	rafb_ram #(
		.WIDTH(8),
		.DEPTH(MEM_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rafb_back #(
		.MEM_BYTES(MEM_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.active   (back_active),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.resp     (resp)
	);

	// result fields
	assign out_word    = resp.word;
	assign out_count   = resp.count;
	assign out_last    = resp.last;
	assign len_clamped = resp.clamped;

endmodule

`default_nettype wire

// ===== hdl/rafb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rafb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] out_word,
	input wire logic [3:0]  out_count,
	input wire logic        out_last,
	input wire logic        len_clamped
);

	// a shown word carries one to eight bytes
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_count != 4'd0) && (out_count <= 4'd8))
		else $error("out_count out of range");

	// only the final word of a frame may be short
	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_count != 4'd8) |-> out_last)
		else $error("short word not marked last");

	// with four bytes or fewer, the unused low half reads as zero
	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_count <= 4'd4) |-> (out_word[31:0] == 32'd0))
		else $error("unused bytes not zero");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word)
			&& $stable(out_count) && $stable(out_last) && $stable(len_clamped))
		else $error("stalled result changed");

endmodule

bind register_access_frame_bridge rafb_checker u_rafb_checker (.*);

`default_nettype wire
